/* sv/tcw_pkg.sv */
// Shared types and constants for the text console writer.
// No dependencies; used by every module of the block.
package tcw_pkg;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;
  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int POS_W       = 11;
  localparam int CELL_W      = 16;

  localparam int Q_DEPTH     = 2;
  localparam int QPTR_W      = $clog2(Q_DEPTH);

  localparam int TAB_STOP    = 8;

  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
  localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CHAR_SPACE};

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    K_PRINT,
    K_BS,
    K_TAB,
    K_CR,
    K_LF,
    K_IGNORE,
    K_CLEAR,
    K_READ,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_BLANK,
    ST_RESP
  } state_t;

endpackage

/* sv/tcw_front.sv */
// Input side: takes items and decodes them into console commands.
// Depends on tcw_pkg; feeds tcw_queue.
module tcw_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: operation[1:0], char_code[9:2], cell_index[20:10], zero fill
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            q_ready,
  input  logic                            init_busy,
  output logic                            q_push,
  output tcw_pkg::cmd_t                   q_cmd
);

  logic [tcw_pkg::CHAR_W-1:0] ch;
  tcw_pkg::kind_t             put_kind;

  assign ch        = in_tdata[9:2];
  assign in_tready = q_ready && !init_busy;
  assign q_push    = in_tvalid && in_tready;

  // signed char: anything with the top bit set is negative and ignored
  always_comb begin
    unique case (ch)
      tcw_pkg::CHAR_BS:  put_kind = tcw_pkg::K_BS;
      tcw_pkg::CHAR_TAB: put_kind = tcw_pkg::K_TAB;
      tcw_pkg::CHAR_CR:  put_kind = tcw_pkg::K_CR;
      tcw_pkg::CHAR_LF:  put_kind = tcw_pkg::K_LF;
      default: begin
        if (!ch[7] && ch >= tcw_pkg::CHAR_SPACE) put_kind = tcw_pkg::K_PRINT;
        else put_kind = tcw_pkg::K_IGNORE;
      end
    endcase
  end

  always_comb begin
    q_cmd.ch  = ch;
    q_cmd.idx = in_tdata[20:10];
    unique case (tcw_pkg::op_t'(in_tdata[1:0]))
      tcw_pkg::OP_PUT:   q_cmd.kind = put_kind;
      tcw_pkg::OP_CLEAR: q_cmd.kind = tcw_pkg::K_CLEAR;
      tcw_pkg::OP_READ:  q_cmd.kind = tcw_pkg::K_READ;
      default:           q_cmd.kind = tcw_pkg::K_NOP;
    endcase
  end

endmodule

/* sv/tcw_queue.sv */
// Short command queue between the decoder and the screen engine.
// Depends on tcw_pkg for the command type and depth.
module tcw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcw_pkg::cmd_t push_cmd,
  output logic          ready,
  output logic          valid,
  output tcw_pkg::cmd_t head_cmd,
  input  logic          pop
);

  tcw_pkg::cmd_t                entries_r [tcw_pkg::Q_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [tcw_pkg::QPTR_W:0]     cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign ready    = cnt_r != (tcw_pkg::QPTR_W+1)'(tcw_pkg::Q_DEPTH);
  assign valid    = cnt_r != '0;
  assign head_cmd = entries_r[rd_ptr_r];
  assign do_push  = push && ready;
  assign do_pop   = pop && valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_cmd;
  end

endmodule

/* sv/tcw_back.sv */
// Screen engine: cell memory, cursor, scroll/clear sweeps and result register.
// Depends on tcw_pkg; pops commands from tcw_queue.
module tcw_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  tcw_pkg::cmd_t                    q_cmd,
  output logic                             q_pop,
  input  logic                             cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             init_busy
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int CT     = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
  localparam int RT     = $clog2(ROWS + 1);
  localparam int PAD_W  = tcw_pkg::OUT_TDATA_W - tcw_pkg::POS_W - tcw_pkg::CELL_W;

  logic [tcw_pkg::CELL_W-1:0] mem [CELLS];
  logic [tcw_pkg::CELL_W-1:0] rd_data_r;
  logic                       mem_we;
  logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
  logic [tcw_pkg::CELL_W-1:0] mem_wdata;

  tcw_pkg::state_t            state_r, state_nxt;
  logic [ADDR_W-1:0]          ptr_r, ptr_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic [tcw_pkg::CELL_W-1:0] blank_r, blank_nxt;
  logic [tcw_pkg::ATTR_W-1:0] attr_r;
  logic                       rd_sel_r, rd_sel_nxt;
  logic                       wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [tcw_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [tcw_pkg::CELL_W-1:0] out_data_r, out_data_nxt;

  logic [CT-1:0]              col_w;
  logic [RT-1:0]              row_w;
  logic                       scroll_need;
  logic [ADDR_W-1:0]          cur_addr;
  logic                       last_cell;
  logic                       idx_ok;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_data_r, out_pos_r};
  assign init_busy  = state_r == tcw_pkg::ST_INIT;
  assign cur_addr   = ADDR_W'(row_r * COLUMNS + col_r);
  assign last_cell  = ptr_r == ADDR_W'(CELLS - 1);
  assign idx_ok     = int'(q_cmd.idx) < CELLS;

  // cursor after a put-char, before the scroll fixup
  always_comb begin
    col_w = CT'(col_r);
    row_w = RT'(row_r);
    case (q_cmd.kind)
      tcw_pkg::K_PRINT: col_w = col_w + 1'b1;
      tcw_pkg::K_BS:    if (col_r != '0) col_w = col_w - 1'b1;
      tcw_pkg::K_TAB:
        col_w = (col_w + CT'(tcw_pkg::TAB_STOP)) & ~CT'(tcw_pkg::TAB_STOP - 1);
      tcw_pkg::K_CR:    col_w = '0;
      tcw_pkg::K_LF: begin
        col_w = '0;
        row_w = row_w + 1'b1;
      end
      default: ;
    endcase
    if (col_w >= CT'(COLUMNS)) begin
      col_w = '0;
      row_w = row_w + 1'b1;
    end
    scroll_need = row_w >= RT'(ROWS);
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    blank_nxt     = blank_r;
    rd_sel_nxt    = rd_sel_r;
    wr_pend_nxt   = 1'b0;
    wr_ptr_nxt    = ptr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = blank_r;
    mem_raddr     = ptr_r;

    unique case (state_r)
      tcw_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = tcw_pkg::RESET_BLANK;
        if (last_cell) begin
          ptr_nxt   = '0;
          state_nxt = tcw_pkg::ST_IDLE;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (q_valid && (!out_valid_r || out_tready)) begin
          q_pop      = 1'b1;
          rd_sel_nxt = 1'b0;
          state_nxt  = tcw_pkg::ST_RESP;
          case (q_cmd.kind)
            tcw_pkg::K_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              blank_nxt = {attr_r, tcw_pkg::CHAR_SPACE};
              ptr_nxt   = '0;
              state_nxt = tcw_pkg::ST_CLEAR;
            end
            tcw_pkg::K_READ: begin
              mem_raddr  = ADDR_W'(q_cmd.idx);
              rd_sel_nxt = idx_ok;
            end
            tcw_pkg::K_NOP: ;
            default: begin
              if (q_cmd.kind == tcw_pkg::K_PRINT) begin
                mem_we    = 1'b1;
                mem_waddr = cur_addr;
                mem_wdata = {attr_r, q_cmd.ch};
              end
              col_nxt = CW'(col_w);
              if (scroll_need) begin
                row_nxt   = RW'(ROWS - 1);
                blank_nxt = {attr_r, tcw_pkg::CHAR_SPACE};
                ptr_nxt   = '0;
                state_nxt = tcw_pkg::ST_SCROLL;
              end else begin
                row_nxt = RW'(row_w);
              end
            end
          endcase
        end
      end
      tcw_pkg::ST_CLEAR, tcw_pkg::ST_BLANK: begin
        mem_we = 1'b1;
        if (last_cell) begin
          ptr_nxt   = '0;
          state_nxt = tcw_pkg::ST_RESP;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // read one row down, write it back in the following cycle
        if (ptr_r < ADDR_W'(COPY_N)) begin
          mem_raddr   = ptr_r + ADDR_W'(COLUMNS);
          wr_pend_nxt = 1'b1;
          wr_ptr_nxt  = ptr_r;
          ptr_nxt     = ptr_r + 1'b1;
        end else begin
          state_nxt = tcw_pkg::ST_BLANK;
        end
      end
      tcw_pkg::ST_RESP: begin
        out_valid_nxt = 1'b1;
        out_pos_nxt   = tcw_pkg::POS_W'(row_r * COLUMNS + col_r);
        out_data_nxt  = rd_sel_r ? rd_data_r : '0;
        state_nxt     = tcw_pkg::ST_IDLE;
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase

    if (wr_pend_r) begin
      mem_we    = 1'b1;
      mem_waddr = wr_ptr_r;
      mem_wdata = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_INIT;
      ptr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      attr_r      <= tcw_pkg::RESET_ATTR;
      rd_sel_r    <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      if (cfg_we) attr_r <= cfg_wdata;
      rd_sel_r    <= rd_sel_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_r    <= blank_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

endmodule

/* sv/text_console_writer.sv */
// Text console writer top level: decoder, command queue and screen engine.
// Depends on tcw_pkg, tcw_front, tcw_queue and tcw_back.
//
//   port group  | dir | handshake          | payload
//   in_*        | in  | in_tvalid/tready   | operation, char_code, cell_index
//   out_*       | out | out_tvalid/tready  | cursor_pos, cell_data
//   cfg_*       | in  | cfg_we             | text_attribute
//
// Put-char without a scroll, read and no-op go from ST_IDLE to ST_RESP. Clear
// sweeps all COLUMNS*ROWS cells; a scroll copies the lower (ROWS-1)*COLUMNS cells
// up one row and then blanks the last row, both bound by the single write port
// of the cell memory. After reset a pass blanks every cell with in_tready low. The
// queue keeps taking items, until it is full, while a result waits on out_tready.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: operation[1:0], char_code[9:2], cell_index[20:10], zero fill
  input  logic [tcw_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: cursor_pos[10:0], cell_data[26:11], zero fill
  output logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [tcw_pkg::ATTR_W-1:0]      cfg_wdata
);

  logic          q_ready, q_push, q_valid, q_pop, init_busy;
  tcw_pkg::cmd_t push_cmd, head_cmd;

  tcw_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .init_busy (init_busy),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tcw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .valid    (q_valid),
    .head_cmd (head_cmd),
    .pop      (q_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .init_busy  (init_busy)
  );

endmodule

/* tb/text_console_writer_test.sv */
// Self-checking bench for text_console_writer: put-char, clear, read and no-op items
// against a cell-level model of the screen and cursor. Depends on tcw_pkg and the RTL.
module text_console_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [tcw_pkg::CHAR_W-1:0] CHAR_TOP = 8'h7F;
  localparam logic [tcw_pkg::IDX_W-1:0] IDX_MAX = '1;

  typedef struct {
    tcw_pkg::op_t op;
    logic [tcw_pkg::CHAR_W-1:0] ch;
    logic [tcw_pkg::IDX_W-1:0] idx;
  } console_cmd_t;

  typedef struct {
    logic [tcw_pkg::POS_W-1:0] pos;
    logic [tcw_pkg::CELL_W-1:0] cell_data;
  } console_view_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tcw_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tcw_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [tcw_pkg::ATTR_W-1:0] cfg_wdata = '0;

  // screen model
  logic [tcw_pkg::CELL_W-1:0] screen_model [0:CELLS-1];
  int cur_col;
  int cur_row;
  logic [tcw_pkg::ATTR_W-1:0] attr_model;

  console_cmd_t pending_cmds[$];
  console_view_t expected_views[$];
  int items_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int error_count = 0;
  bit in_taken = 1'b0;
  bit idle_enable = 1'b1;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS(ROWS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic logic [tcw_pkg::CELL_W-1:0] blank_model();
    return {attr_model, tcw_pkg::CHAR_SPACE};
  endfunction

  function automatic void scroll_model();
    int k;
    for (k = 0; k < (ROWS - 1) * COLUMNS; k++) screen_model[k] = screen_model[k + COLUMNS];
    for (k = (ROWS - 1) * COLUMNS; k < CELLS; k++) screen_model[k] = blank_model();
    cur_row = ROWS - 1;
  endfunction

  function automatic void console_step(input tcw_pkg::op_t op,
                                       input logic [tcw_pkg::CHAR_W-1:0] ch,
                                       input logic [tcw_pkg::IDX_W-1:0] idx,
                                       output console_view_t view);
    int k;
    int addr;
    view.cell_data = '0;
    case (op)
      tcw_pkg::OP_PUT: begin
        if (ch == tcw_pkg::CHAR_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (ch == tcw_pkg::CHAR_TAB) begin
          cur_col = (cur_col + tcw_pkg::TAB_STOP) & ~(tcw_pkg::TAB_STOP - 1);
        end else if (ch == tcw_pkg::CHAR_CR) begin
          cur_col = 0;
        end else if (ch == tcw_pkg::CHAR_LF) begin
          cur_col = 0;
          cur_row++;
        end else if (ch >= tcw_pkg::CHAR_SPACE && ch <= CHAR_TOP) begin
          addr = cur_row * COLUMNS + cur_col;
          if (addr < CELLS) screen_model[addr] = {attr_model, ch};
          cur_col++;
        end
        // high bytes and other control codes fall through untouched
        if (cur_col >= COLUMNS) begin
          cur_col = 0;
          cur_row++;
        end
        if (cur_row >= ROWS) scroll_model();
      end
      tcw_pkg::OP_CLEAR: begin
        for (k = 0; k < CELLS; k++) screen_model[k] = blank_model();
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::OP_READ: begin
        if (idx < CELLS) view.cell_data = screen_model[idx];
      end
      default: ;
    endcase
    view.pos = tcw_pkg::POS_W'(cur_row * COLUMNS + cur_col);
  endfunction

  function automatic int idle_cycles();
    int r;
    if (!idle_enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // accepted input items and register writes update the model
  always @(posedge clk) begin : in_capture
    console_view_t view;
    in_taken = rst_n && in_tvalid && in_tready;
    if (in_taken) begin
      console_step(tcw_pkg::op_t'(in_tdata[1:0]), in_tdata[9:2], in_tdata[20:10], view);
      expected_views.push_back(view);
      items_accepted++;
    end
    if (rst_n && cfg_we) attr_model = cfg_wdata;
  end

  always @(posedge clk) begin : result_monitor
    console_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (expected_views.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata), 0);
      end else begin
        want = expected_views.pop_front();
        if (out_tdata[10:0] !== want.pos)
          report_mismatch("cursor_pos", int'(out_tdata[10:0]), int'(want.pos));
        if (out_tdata[26:11] !== want.cell_data)
          report_mismatch("cell_data", int'(out_tdata[26:11]), int'(want.cell_data));
      end
    end
  end

  always @(negedge clk) begin : item_driver
    console_cmd_t cmd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        cmd = pending_cmds.pop_front();
        in_tdata <= {3'b000, cmd.idx, cmd.ch, cmd.op};
        in_tvalid <= 1'b1;
        send_gap = idle_cycles();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // one long hold-off lets the input queue fill and back up
  always @(negedge clk) begin : result_receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_checked >= 50) begin
      hold_done = 1'b1;
      hold_left = 500;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = idle_cycles();
    end
  end

  task automatic push_cmd(input tcw_pkg::op_t op, input logic [tcw_pkg::CHAR_W-1:0] ch,
                          input logic [tcw_pkg::IDX_W-1:0] idx);
    console_cmd_t cmd;
    cmd.op = op;
    cmd.ch = ch;
    cmd.idx = idx;
    pending_cmds.push_back(cmd);
    items_queued++;
  endtask

  task automatic push_put(input logic [tcw_pkg::CHAR_W-1:0] ch);
    push_cmd(tcw_pkg::OP_PUT, ch, tcw_pkg::IDX_W'($urandom_range(0, 2047)));
  endtask

  task automatic push_read(input logic [tcw_pkg::IDX_W-1:0] idx);
    push_cmd(tcw_pkg::OP_READ, tcw_pkg::CHAR_W'($urandom_range(0, 255)), idx);
  endtask

  task automatic wait_console_idle();
    while (items_accepted != items_queued || expected_views.size() != 0) @(negedge clk);
  endtask

  task automatic write_text_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
    wait_console_idle();
    repeat (4) @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [tcw_pkg::CHAR_W-1:0] junk_byte();
    logic [tcw_pkg::CHAR_W-1:0] b;
    do begin
      b = tcw_pkg::CHAR_W'($urandom_range(0, 255));
    end while ((b >= tcw_pkg::CHAR_SPACE && b <= CHAR_TOP) || b == tcw_pkg::CHAR_BS ||
               b == tcw_pkg::CHAR_TAB || b == tcw_pkg::CHAR_CR || b == tcw_pkg::CHAR_LF);
    return b;
  endfunction

  task automatic queue_console_traffic(input int target);
    int start;
    int noise;
    int kind;
    int n;
    start = items_queued;
    noise = 0;
    while (items_queued - start - noise < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        n = $urandom_range(0, 8);
        repeat (n) push_put(tcw_pkg::CHAR_W'($urandom_range(32, 127)));
        if ($urandom_range(0, 1)) push_put(tcw_pkg::CHAR_CR);
        push_put(tcw_pkg::CHAR_LF);
      end else if (kind < 52) begin
        repeat ($urandom_range(2, 8)) push_put(tcw_pkg::CHAR_LF);
      end else if (kind < 60) begin
        repeat ($urandom_range(1, 11)) push_put(tcw_pkg::CHAR_TAB);
      end else if (kind < 67) begin
        repeat ($urandom_range(1, 4)) push_put(tcw_pkg::CHAR_BS);
        repeat ($urandom_range(0, 3)) push_put(tcw_pkg::CHAR_W'($urandom_range(32, 127)));
      end else if (kind < 84) begin
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 9) == 0)
            push_read(tcw_pkg::IDX_W'($urandom_range(CELLS, 2047)));
          else push_read(tcw_pkg::IDX_W'($urandom_range(0, CELLS - 1)));
        end
      end else if (kind < 98) begin
        if ($urandom_range(0, 2) == 0)
          push_cmd(tcw_pkg::OP_NONE, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                   tcw_pkg::IDX_W'($urandom_range(0, 2047)));
        else push_put(junk_byte());
        noise++;
      end else begin
        push_cmd(tcw_pkg::OP_CLEAR, tcw_pkg::CHAR_W'($urandom_range(0, 255)),
                 tcw_pkg::IDX_W'($urandom_range(0, 2047)));
      end
    end
  endtask

  initial begin : stimulus
    int k;
    for (k = 0; k < CELLS; k++) screen_model[k] = tcw_pkg::RESET_BLANK;
    cur_col = 0;
    cur_row = 0;
    attr_model = tcw_pkg::RESET_ATTR;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset contents, edge reads, byte classes, cursor controls, no-op, clear
    push_read('0);
    push_read(tcw_pkg::IDX_W'(CELLS - 1));
    push_read(IDX_MAX);
    push_read(tcw_pkg::IDX_W'(CELLS));
    push_put(8'h41);
    push_put(tcw_pkg::CHAR_SPACE);
    push_put(CHAR_TOP);
    push_put(8'h80);
    push_put(8'hFF);
    push_put(8'h1F);
    push_put(8'h00);
    push_read('0);
    push_read(tcw_pkg::IDX_W'(2));
    push_put(tcw_pkg::CHAR_BS);
    push_put(tcw_pkg::CHAR_CR);
    push_put(tcw_pkg::CHAR_BS);
    push_put(tcw_pkg::CHAR_TAB);
    push_put(tcw_pkg::CHAR_TAB);
    push_put(tcw_pkg::CHAR_LF);
    push_cmd(tcw_pkg::OP_NONE, 8'hFF, IDX_MAX);
    push_cmd(tcw_pkg::OP_CLEAR, 8'h00, '0);
    push_read('0);
    push_put(8'h41);
    push_read('0);

    write_text_attribute(8'h00);
    queue_console_traffic(80);

    write_text_attribute(8'hFF);
    idle_enable = 1'b0;
    queue_console_traffic(90);

    write_text_attribute(tcw_pkg::ATTR_W'($urandom_range(1, 254)));
    idle_enable = 1'b1;
    queue_console_traffic(90);

    wait_console_idle();
    repeat (50) @(negedge clk);
    if (expected_views.size() != 0)
      report_mismatch("results never delivered", 0, expected_views.size());
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #25_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
